// ===== sv/ple_pkg.sv =====
// shared constants, codes and command/status types of the positional list engine
package ple_pkg;

   // list sizing
   localparam int CAPACITY    = 16;
   localparam int MAX_RESULTS = 16;
   localparam int RD_LIMIT    = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // field widths
   localparam int OP_W     = 3;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = 5;

   // width for position and count compares
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // opcodes
   localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_VAL  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_ALL = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_CAP,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SRCH,
      ST_RDOUT
   } state_type;

   // walk pointer updates
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_INC,
      PTR_DEC,
      PTR_COUNT,
      PTR_DEL
   } ptr_op_type;

   // target index updates
   typedef enum logic [1:0] {
      TGT_HOLD,
      TGT_INS,
      TGT_PTR
   } tgt_op_type;

   // memory read address select
   typedef enum logic [1:0] {
      RD_ZERO,
      RD_DEL,
      RD_DEC,
      RD_INC
   } rd_sel_type;

   // memory write address/data select
   typedef enum logic [1:0] {
      WR_TAIL,
      WR_PTR,
      WR_TGT
   } wr_sel_type;

   // entry count updates
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   // result payload source
   typedef enum logic [2:0] {
      RS_ZERO,
      RS_APPEND,
      RS_INSERT,
      RS_DELETE,
      RS_READ
   } rsp_src_type;

   // controller to datapath commands
   typedef struct packed {
      logic                latch;
      ptr_op_type          ptr_op;
      tgt_op_type          tgt_op;
      logic                hold_ld;
      rd_sel_type          rd_sel;
      logic                wr_en;
      wr_sel_type          wr_sel;
      cnt_op_type          cnt_op;
      logic                rsp_en;
      logic [STATUS_W-1:0] rsp_status;
      rsp_src_type         rsp_src;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            ins_bad;
      logic            del_bad;
      logic            ins_more;
      logic            del_more;
      logic            match;
      logic            rd_last;
   } dp_status_type;

endpackage

// ===== sv/ple_datapath.sv =====
// datapath of the positional list engine: entry memory, pointers, count and result register
module ple_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ple_pkg::ctrl_cmd_type            cmd,
   output ple_pkg::dp_status_type           sts,
   input  logic [ple_pkg::OP_W-1:0]         req_opcode,
   input  logic signed [ple_pkg::VAL_W-1:0] req_item_value,
   input  logic [ple_pkg::POS_W-1:0]        req_position,
   output logic                             rsp_strobe,
   output logic [ple_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0] rsp_out_value,
   output logic [ple_pkg::POS_W-1:0]        rsp_out_position,
   output logic [ple_pkg::ENTRY_W-1:0]      rsp_entry_count,
   output logic                             rsp_last
);

   localparam int IW = ple_pkg::IDX_W;
   localparam int CW = ple_pkg::CNT_W;
   localparam int MW = ple_pkg::CMP_W;
   localparam int VW = ple_pkg::VAL_W;
   localparam int PW = ple_pkg::POS_W;

   // entry memory
   logic [VW-1:0] mem_ff [ple_pkg::CAPACITY];
   logic [VW-1:0] mem_q_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic [VW-1:0] wr_data;

   // latched item and working registers
   logic [ple_pkg::OP_W-1:0] op_ff;
   logic [VW-1:0]            val_ff;
   logic [PW-1:0]            pos_ff;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            ptr_ff, ptr_in;
   logic [IW-1:0]            tgt_ff, tgt_in;
   logic [VW-1:0]            hold_ff;

   // result registers
   logic                         rsp_strobe_ff;
   logic [ple_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [VW-1:0]                rsp_value_ff, rsp_value_in;
   logic [PW-1:0]                rsp_pos_ff, rsp_pos_in;
   logic [ple_pkg::ENTRY_W-1:0]  rsp_count_ff;
   logic                         rsp_last_ff, rsp_last_in;

   // derived compare values
   logic [MW-1:0] pos_ext, cnt_ext, ptr_inc_ext, tgt_inc_ext;
   logic [IW-1:0] pos_idx, del_idx;
   logic [CW-1:0] rd_count;

   assign pos_ext     = MW'(pos_ff);
   assign cnt_ext     = MW'(cnt_ff);
   assign ptr_inc_ext = MW'(ptr_ff) + MW'(1);
   assign tgt_inc_ext = MW'(tgt_ff) + MW'(1);
   assign pos_idx     = IW'(pos_ext - MW'(1));
   assign del_idx     = (op_ff == ple_pkg::OP_DEL_HEAD) ? '0 : pos_idx;
   assign rd_count    = (cnt_ff > CW'(ple_pkg::RD_LIMIT)) ? CW'(ple_pkg::RD_LIMIT) : cnt_ff;

   // status to the controller
   always_comb begin
      sts.op       = op_ff;
      sts.empty    = (cnt_ff == '0);
      sts.full     = (cnt_ff >= CW'(ple_pkg::CAPACITY));
      sts.ins_bad  = (pos_ff == '0) || (pos_ext > cnt_ext + MW'(1));
      sts.del_bad  = (pos_ff == '0) || (pos_ext > cnt_ext);
      sts.ins_more = (MW'(ptr_ff) > MW'(tgt_ff));
      sts.del_more = (ptr_inc_ext < cnt_ext);
      sts.match    = (mem_q_ff == val_ff);
      sts.rd_last  = (ptr_inc_ext == MW'(rd_count));
   end

   // read and write address selection
   always_comb begin
      case (cmd.rd_sel)
         ple_pkg::RD_ZERO: rd_addr = '0;
         ple_pkg::RD_DEL:  rd_addr = del_idx;
         ple_pkg::RD_DEC:  rd_addr = IW'(ptr_ff - CW'(1));
         ple_pkg::RD_INC:  rd_addr = IW'(ptr_inc_ext);
         default:          rd_addr = '0;
      endcase
      case (cmd.wr_sel)
         ple_pkg::WR_TAIL: begin
            wr_addr = IW'(cnt_ff);
            wr_data = val_ff;
         end
         ple_pkg::WR_PTR: begin
            wr_addr = IW'(ptr_ff);
            wr_data = mem_q_ff;
         end
         ple_pkg::WR_TGT: begin
            wr_addr = tgt_ff;
            wr_data = val_ff;
         end
         default: begin
            wr_addr = '0;
            wr_data = val_ff;
         end
      endcase
   end

   // memory port, registered read
   always_ff @(posedge clock) begin
      mem_q_ff <= mem_ff[rd_addr];
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // pointer, target and count next values
   always_comb begin
      case (cmd.ptr_op)
         ple_pkg::PTR_HOLD:  ptr_in = ptr_ff;
         ple_pkg::PTR_ZERO:  ptr_in = '0;
         ple_pkg::PTR_INC:   ptr_in = CW'(ptr_inc_ext);
         ple_pkg::PTR_DEC:   ptr_in = ptr_ff - CW'(1);
         ple_pkg::PTR_COUNT: ptr_in = cnt_ff;
         ple_pkg::PTR_DEL:   ptr_in = CW'(del_idx);
         default:            ptr_in = ptr_ff;
      endcase
      case (cmd.tgt_op)
         ple_pkg::TGT_HOLD: tgt_in = tgt_ff;
         ple_pkg::TGT_INS:  tgt_in = pos_idx;
         ple_pkg::TGT_PTR:  tgt_in = IW'(ptr_ff);
         default:           tgt_in = tgt_ff;
      endcase
      case (cmd.cnt_op)
         ple_pkg::CNT_HOLD: cnt_in = cnt_ff;
         ple_pkg::CNT_INC:  cnt_in = cnt_ff + CW'(1);
         ple_pkg::CNT_DEC:  cnt_in = cnt_ff - CW'(1);
         default:           cnt_in = cnt_ff;
      endcase
   end

   // result payload selection
   always_comb begin
      rsp_last_in = 1'b1;
      case (cmd.rsp_src)
         ple_pkg::RS_ZERO: begin
            rsp_value_in = '0;
            rsp_pos_in   = '0;
         end
         ple_pkg::RS_APPEND: begin
            rsp_value_in = val_ff;
            rsp_pos_in   = PW'(cnt_in);
         end
         ple_pkg::RS_INSERT: begin
            rsp_value_in = val_ff;
            rsp_pos_in   = pos_ff;
         end
         ple_pkg::RS_DELETE: begin
            rsp_value_in = hold_ff;
            rsp_pos_in   = PW'(tgt_inc_ext);
         end
         ple_pkg::RS_READ: begin
            rsp_value_in = mem_q_ff;
            rsp_pos_in   = PW'(ptr_inc_ext);
            rsp_last_in  = sts.rd_last;
         end
         default: begin
            rsp_value_in = '0;
            rsp_pos_in   = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= cmd.rsp_en;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= req_opcode;
         val_ff <= req_item_value;
         pos_ff <= req_position;
      end
      ptr_ff <= ptr_in;
      tgt_ff <= tgt_in;
      if (cmd.hold_ld) begin
         hold_ff <= mem_q_ff;
      end
      if (cmd.rsp_en) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_value_ff  <= rsp_value_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_count_ff  <= ple_pkg::ENTRY_W'(cnt_in);
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(ple_pkg::CAPACITY))
      else $error("entry count above capacity");
   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_op == ple_pkg::CNT_INC |-> !sts.full)
      else $error("count grown on a full list");
   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_op == ple_pkg::CNT_DEC |-> !sts.empty)
      else $error("count shrunk on an empty list");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != ple_pkg::STAT_OK)
      |-> (rsp_value_ff == '0 && rsp_pos_ff == '0))
      else $error("error result carries a value or position");
`endif

endmodule

// ===== sv/ple_ctrl.sv =====
// controller state machine of the positional list engine
module ple_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ple_pkg::dp_status_type sts,
   output ple_pkg::ctrl_cmd_type  cmd
);

   ple_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.latch      = 1'b0;
      cmd.ptr_op     = ple_pkg::PTR_HOLD;
      cmd.tgt_op     = ple_pkg::TGT_HOLD;
      cmd.hold_ld    = 1'b0;
      cmd.rd_sel     = ple_pkg::RD_ZERO;
      cmd.wr_en      = 1'b0;
      cmd.wr_sel     = ple_pkg::WR_TAIL;
      cmd.cnt_op     = ple_pkg::CNT_HOLD;
      cmd.rsp_en     = 1'b0;
      cmd.rsp_status = ple_pkg::STAT_OK;
      cmd.rsp_src    = ple_pkg::RS_ZERO;
      case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ple_pkg::ST_CHECK;
            end
         end
         // decode the item and check it against the list
         ple_pkg::ST_CHECK: begin
            state_in = ple_pkg::ST_IDLE;
            case (sts.op)
               ple_pkg::OP_APPEND: begin
                  cmd.rsp_en = 1'b1;
                  if (sts.full) begin
                     cmd.rsp_status = ple_pkg::STAT_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = ple_pkg::WR_TAIL;
                     cmd.cnt_op  = ple_pkg::CNT_INC;
                     cmd.rsp_src = ple_pkg::RS_APPEND;
                  end
               end
               ple_pkg::OP_INSERT: begin
                  if (sts.full) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ple_pkg::STAT_FULL;
                  end else if (sts.ins_bad) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ple_pkg::STAT_BADPOS;
                  end else begin
                     cmd.tgt_op = ple_pkg::TGT_INS;
                     cmd.ptr_op = ple_pkg::PTR_COUNT;
                     state_in   = ple_pkg::ST_INS_RD;
                  end
               end
               ple_pkg::OP_DEL_HEAD, ple_pkg::OP_DEL_POS: begin
                  if (sts.empty) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ple_pkg::STAT_EMPTY;
                  end else if (sts.op == ple_pkg::OP_DEL_POS && sts.del_bad) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ple_pkg::STAT_BADPOS;
                  end else begin
                     cmd.rd_sel = ple_pkg::RD_DEL;
                     cmd.ptr_op = ple_pkg::PTR_DEL;
                     state_in   = ple_pkg::ST_DEL_CAP;
                  end
               end
               ple_pkg::OP_DEL_VAL, ple_pkg::OP_READ_ALL: begin
                  if (sts.empty) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ple_pkg::STAT_EMPTY;
                  end else begin
                     cmd.rd_sel = ple_pkg::RD_ZERO;
                     cmd.ptr_op = ple_pkg::PTR_ZERO;
                     state_in   = (sts.op == ple_pkg::OP_DEL_VAL) ?
                                  ple_pkg::ST_SRCH : ple_pkg::ST_RDOUT;
                  end
               end
               default: begin
                  cmd.rsp_en = 1'b1;
               end
            endcase
         end
         // insert: move entries up one slot from the tail down to the target
         ple_pkg::ST_INS_RD: begin
            if (sts.ins_more) begin
               cmd.rd_sel = ple_pkg::RD_DEC;
               state_in   = ple_pkg::ST_INS_WR;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ple_pkg::WR_TGT;
               cmd.cnt_op  = ple_pkg::CNT_INC;
               cmd.rsp_en  = 1'b1;
               cmd.rsp_src = ple_pkg::RS_INSERT;
               state_in    = ple_pkg::ST_IDLE;
            end
         end
         ple_pkg::ST_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ple_pkg::WR_PTR;
            cmd.ptr_op = ple_pkg::PTR_DEC;
            state_in   = ple_pkg::ST_INS_RD;
         end
         // delete: keep the removed value, then close the gap
         ple_pkg::ST_DEL_CAP: begin
            cmd.hold_ld = 1'b1;
            cmd.tgt_op  = ple_pkg::TGT_PTR;
            state_in    = ple_pkg::ST_DEL_RD;
         end
         ple_pkg::ST_DEL_RD: begin
            if (sts.del_more) begin
               cmd.rd_sel = ple_pkg::RD_INC;
               state_in   = ple_pkg::ST_DEL_WR;
            end else begin
               cmd.cnt_op  = ple_pkg::CNT_DEC;
               cmd.rsp_en  = 1'b1;
               cmd.rsp_src = ple_pkg::RS_DELETE;
               state_in    = ple_pkg::ST_IDLE;
            end
         end
         ple_pkg::ST_DEL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ple_pkg::WR_PTR;
            cmd.ptr_op = ple_pkg::PTR_INC;
            state_in   = ple_pkg::ST_DEL_RD;
         end
         // value search, one entry a cycle
         ple_pkg::ST_SRCH: begin
            if (sts.match) begin
               cmd.hold_ld = 1'b1;
               cmd.tgt_op  = ple_pkg::TGT_PTR;
               state_in    = ple_pkg::ST_DEL_RD;
            end else if (sts.del_more) begin
               cmd.rd_sel = ple_pkg::RD_INC;
               cmd.ptr_op = ple_pkg::PTR_INC;
            end else begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ple_pkg::STAT_NOTFOUND;
               state_in       = ple_pkg::ST_IDLE;
            end
         end
         // read-out, one entry a cycle
         ple_pkg::ST_RDOUT: begin
            cmd.rsp_en  = 1'b1;
            cmd.rsp_src = ple_pkg::RS_READ;
            if (sts.rd_last) begin
               state_in = ple_pkg::ST_IDLE;
            end else begin
               cmd.rd_sel = ple_pkg::RD_INC;
               cmd.ptr_op = ple_pkg::PTR_INC;
            end
         end
         default: begin
            state_in = ple_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ple_pkg::ST_IDLE);

`ifndef NO_ASSERTIONS
   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_en && (cmd.rsp_src != ple_pkg::RS_READ || sts.rd_last))
      |=> state_ff == ple_pkg::ST_IDLE)
      else $error("final result not followed by idle");
   a_write_has_owner: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (state_ff == ple_pkg::ST_CHECK || state_ff == ple_pkg::ST_INS_RD
                     || state_ff == ple_pkg::ST_INS_WR || state_ff == ple_pkg::ST_DEL_WR))
      else $error("memory write outside an update step");
   a_accept_in_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |-> (state_ff == ple_pkg::ST_IDLE && start))
      else $error("item taken while busy");
`endif

endmodule

// ===== sv/positional_list_engine_top.sv =====
// top level of the positional list engine: controller plus datapath
//
// Keeps an ordered list of up to 16 signed 32-bit entries in a memory with
// one write port and one registered read port.
// Request channel: drive req_opcode, req_item_value and req_position with
// start high; the item is taken at the edge where start is high and busy
// is low. busy stays high until the item's last result has been issued.
// Result channel: each result is shown for one cycle with rsp_strobe high;
// rsp_last marks the final result of an item. The receiver cannot stall.
// Read-out issues one result per cycle. In the shifting loops each moved
// entry is read, then written once its registered read data is back. A new
// item may be accepted at the edge that ends the last result's strobe cycle.
// Reset empties the list; stored values are not cleared and need not be.
module positional_list_engine_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ple_pkg::OP_W-1:0]         req_opcode,
   input  logic signed [ple_pkg::VAL_W-1:0] req_item_value,
   input  logic [ple_pkg::POS_W-1:0]        req_position,
   output logic                             rsp_strobe,
   output logic [ple_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0] rsp_out_value,
   output logic [ple_pkg::POS_W-1:0]        rsp_out_position,
   output logic [ple_pkg::ENTRY_W-1:0]      rsp_entry_count,
   output logic                             rsp_last
);

   ple_pkg::ctrl_cmd_type  cmd;
   ple_pkg::dp_status_type sts;

   // sequencer
   ple_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // storage and result formation
   ple_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_item_value   (req_item_value),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_position (rsp_out_position),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== tb/positional_list_checker.sv =====
// checker for the positional list engine: predicts every result and compares it
`timescale 1ns / 100ps

module positional_list_checker
   import ple_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic signed [VAL_W-1:0]   req_item_value,
   input  logic [POS_W-1:0]          req_position,
   input  logic                      rsp_strobe,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic signed [VAL_W-1:0]   rsp_out_value,
   input  logic [POS_W-1:0]          rsp_out_position,
   input  logic [ENTRY_W-1:0]        rsp_entry_count,
   input  logic                      rsp_last,
   output int                        fail_count,
   output int                        pending_count,
   output int                        items_seen,
   output int                        results_seen
);

   // one result of the list engine
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
      logic [ENTRY_W-1:0]      count;
      logic                    last;
   } list_result_type;

   list_result_type         expected_results[$];
   list_result_type         got;
   list_result_type         want;
   logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
   int                      shadow_count;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      items_seen    = 0;
      results_seen  = 0;
      shadow_count  = 0;
   end

   // queue one expected result, entry count taken after the update
   task automatic post_result(input logic [STATUS_W-1:0] st,
                              input logic signed [VAL_W-1:0] v,
                              input int p, input logic fin);
      list_result_type r;
      r.status   = st;
      r.value    = v;
      r.position = p[POS_W-1:0];
      r.count    = shadow_count[ENTRY_W-1:0];
      r.last     = fin;
      expected_results.push_back(r);
   endtask

   // take out the entry at a 0-based index and close the gap
   task automatic remove_entry(input int idx, output logic signed [VAL_W-1:0] v);
      v = shadow_entries[idx];
      for (int i = idx; i + 1 < shadow_count; i++)
         shadow_entries[i] = shadow_entries[i + 1];
      shadow_count--;
   endtask

   // work out the results of one accepted item and update the shadow list
   task automatic predict_list_op(input logic [OP_W-1:0] op,
                                  input logic signed [VAL_W-1:0] val,
                                  input logic [POS_W-1:0] pos);
      logic signed [VAL_W-1:0] v;
      int                      p;
      int                      n;
      int                      hit;
      p   = int'(pos);
      hit = -1;
      case (op)
         OP_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               post_result(STAT_FULL, '0, 0, 1'b1);
            end else begin
               shadow_entries[shadow_count] = val;
               shadow_count++;
               post_result(STAT_OK, val, shadow_count, 1'b1);
            end
         end
         OP_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               post_result(STAT_FULL, '0, 0, 1'b1);
            end else if (p == 0 || p > shadow_count + 1) begin
               post_result(STAT_BADPOS, '0, 0, 1'b1);
            end else begin
               for (int i = shadow_count; i > p - 1; i--)
                  shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[p - 1] = val;
               shadow_count++;
               post_result(STAT_OK, val, p, 1'b1);
            end
         end
         OP_DEL_HEAD: begin
            if (shadow_count == 0) begin
               post_result(STAT_EMPTY, '0, 0, 1'b1);
            end else begin
               remove_entry(0, v);
               post_result(STAT_OK, v, 1, 1'b1);
            end
         end
         OP_DEL_POS: begin
            if (shadow_count == 0) begin
               post_result(STAT_EMPTY, '0, 0, 1'b1);
            end else if (p == 0 || p > shadow_count) begin
               post_result(STAT_BADPOS, '0, 0, 1'b1);
            end else begin
               remove_entry(p - 1, v);
               post_result(STAT_OK, v, p, 1'b1);
            end
         end
         OP_DEL_VAL: begin
            if (shadow_count == 0) begin
               post_result(STAT_EMPTY, '0, 0, 1'b1);
            end else begin
               // only the first equal entry goes
               for (int i = 0; i < shadow_count && hit < 0; i++)
                  if (shadow_entries[i] == val) hit = i;
               if (hit < 0) begin
                  post_result(STAT_NOTFOUND, '0, 0, 1'b1);
               end else begin
                  remove_entry(hit, v);
                  post_result(STAT_OK, v, hit + 1, 1'b1);
               end
            end
         end
         OP_READ_ALL: begin
            if (shadow_count == 0) begin
               post_result(STAT_EMPTY, '0, 0, 1'b1);
            end else begin
               n = (shadow_count > RD_LIMIT) ? RD_LIMIT : shadow_count;
               for (int i = 0; i < n; i++)
                  post_result(STAT_OK, shadow_entries[i], i + 1, i + 1 == n);
            end
         end
         // spare opcodes leave the list alone
         default: post_result(STAT_OK, '0, 0, 1'b1);
      endcase
   endtask

   // compare results first, then predict the item taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            results_seen++;
            got = '{rsp_status, rsp_out_value, rsp_out_position, rsp_entry_count, rsp_last};
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result st=%0d val=%0d pos=%0d cnt=%0d last=%0d",
                           $realtime, got.status, got.value, got.position, got.count,
                           got.last);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected st=%0d val=%0d pos=%0d cnt=%0d last=%0d",
                              want.status, want.value, want.position, want.count,
                              want.last);
                     $display("   actual   st=%0d val=%0d pos=%0d cnt=%0d last=%0d",
                              got.status, got.value, got.position, got.count, got.last);
                  end
                  fail_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            items_seen++;
            predict_list_op(req_opcode, req_item_value, req_position);
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== tb/tb_positional_list_engine_top.sv =====
// testbench top for the positional list engine: stimulus, checker hookup and verdict
`timescale 1ns / 100ps

module tb_positional_list_engine_top;
   import ple_pkg::*;

   // opcodes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS = 150;
   localparam int QUIET_TAIL   = 30;
   localparam int PHASE_LEN    = 24;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [OP_W-1:0]         req_opcode;
   logic signed [VAL_W-1:0] req_item_value;
   logic [POS_W-1:0]        req_position;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   logic signed [VAL_W-1:0] rsp_out_value;
   logic [POS_W-1:0]        rsp_out_position;
   logic [ENTRY_W-1:0]      rsp_entry_count;
   logic                    rsp_last;

   int fail_count;
   int pending_count;
   int items_seen;
   int results_seen;

   positional_list_engine_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_item_value   (req_item_value),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_position (rsp_out_position),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

   positional_list_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_item_value   (req_item_value),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_position (rsp_out_position),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .items_seen       (items_seen),
      .results_seen     (results_seen)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // present one item at a falling edge and hold it until the block takes it
   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                            input logic [POS_W-1:0] pos);
      req_opcode     = op;
      req_item_value = val;
      req_position   = pos;
      start          = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   // values drawn mostly from a small set so that searches hit
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3, 4,
         5, 6:    return VAL_W'($urandom_range(0, 5));
         default: return $urandom;
      endcase
   endfunction

   // positions mostly from 1 to CAPACITY + 1, some zero or up to 255
   function automatic logic [POS_W-1:0] pick_position();
      case ($urandom_range(0, 9))
         0:       return POS_W'($urandom_range(0, 255));
         1:       return '0;
         default: return POS_W'($urandom_range(1, CAPACITY + 1));
      endcase
   endfunction

   // growing phases favor appends and inserts, shrinking phases favor deletes
   function automatic logic [OP_W-1:0] pick_opcode(input bit grow);
      int r;
      r = $urandom_range(0, 99);
      if (grow) begin
         if (r < 45) return OP_APPEND;
         if (r < 75) return OP_INSERT;
         if (r < 80) return OP_DEL_HEAD;
         if (r < 85) return OP_DEL_POS;
         if (r < 90) return OP_DEL_VAL;
         if (r < 97) return OP_READ_ALL;
      end else begin
         if (r < 8)  return OP_APPEND;
         if (r < 15) return OP_INSERT;
         if (r < 40) return OP_DEL_HEAD;
         if (r < 65) return OP_DEL_POS;
         if (r < 88) return OP_DEL_VAL;
         if (r < 96) return OP_READ_ALL;
      end
      return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
   endfunction

   // stimulus
   initial begin
      int guard;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_APPEND;
      req_item_value = '0;
      req_position   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list on read-out and every delete opcode, then spare opcodes
      send_item(OP_READ_ALL, 32'sd9, 8'd1);
      send_item(OP_DEL_HEAD, 32'sd0, 8'd0);
      send_item(OP_DEL_POS, 32'sd0, 8'd1);
      send_item(OP_DEL_VAL, 32'sd3, 8'd0);
      send_item(OP_SPARE_A, 32'sh7fff_ffff, 8'd255);
      send_item(OP_SPARE_B, 32'sh8000_0000, 8'd1);
      // insert position checks on an empty list
      send_item(OP_INSERT, 32'sd11, 8'd0);
      send_item(OP_INSERT, 32'sd11, 8'd2);
      // build a short list with extreme values and a duplicate
      send_item(OP_INSERT, 32'sh8000_0000, 8'd1);
      send_item(OP_APPEND, 32'sh7fff_ffff, 8'd0);
      send_item(OP_APPEND, 32'sd0, 8'd0);
      send_item(OP_INSERT, -32'sd1, 8'd4);
      send_item(OP_INSERT, 32'sd0, 8'd2);
      // first match removed, then a missing value
      send_item(OP_DEL_VAL, 32'sd0, 8'd0);
      send_item(OP_DEL_VAL, 32'sd12345, 8'd0);
      // bad positions on a non-empty list
      send_item(OP_INSERT, 32'sd5, 8'd0);
      send_item(OP_INSERT, 32'sd5, 8'd6);
      send_item(OP_INSERT, 32'sh5555_aaaa, 8'd255);
      send_item(OP_DEL_POS, 32'sd0, 8'd0);
      send_item(OP_DEL_POS, 32'sd0, 8'd5);
      send_item(OP_DEL_POS, 32'sd0, 8'd255);
      // delete the tail, read out, delete the head
      send_item(OP_DEL_POS, 32'sd0, 8'd4);
      send_item(OP_READ_ALL, 32'sd0, 8'd0);
      send_item(OP_DEL_HEAD, 32'sd0, 8'd0);

      // random phases alternating growth and drain, no idling near the end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         send_item(pick_opcode(((n / PHASE_LEN) % 2) == 0), pick_value(), pick_position());
      end
      start = 1'b0;

      // drain outstanding results, then let the block settle
      guard = 0;
      while (pending_count != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (50) @(posedge clock);

      $display("run covered %0d items over all opcodes and list fill levels", items_seen);
      $display("%0d results checked, %0d still outstanding", results_seen, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS positional_list_engine_top");
      end else begin
         $display("FAIL positional_list_engine_top");
      end
      $finish;
   end

   // hard stop if the handshake hangs
   initial begin
      #2000000;
      $display("FAIL positional_list_engine_top");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ple_pkg.sv
sv/ple_datapath.sv
sv/ple_ctrl.sv
sv/positional_list_engine_top.sv
tb/positional_list_checker.sv
tb/tb_positional_list_engine_top.sv
